// ===== src/blle_pkg.sv =====
// Shared types and codes for the bounded linked list engine.
// Used by blle_store, blle_ctrl and bounded_linked_list_engine_unit.
package blle_pkg;

   // operation codes carried in the request tuser
   localparam logic [2:0] FUNC_APPEND       = 3'd0;
   localparam logic [2:0] FUNC_PREPEND      = 3'd1;
   localparam logic [2:0] FUNC_REMOVE_VAL   = 3'd2;
   localparam logic [2:0] FUNC_REMOVE_LAST  = 3'd3;
   localparam logic [2:0] FUNC_REMOVE_FIRST = 3'd4;

   // result status codes
   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_EMPTY   = 2'd1,
      ST_FULL    = 2'd2,
      ST_MISSING = 2'd3
   } status_type;

   // write strobes from the sequencer to the node store
   typedef struct packed {
      logic val_we;
      logic link_we;
   } wr_ctl_type;

endpackage

// ===== src/bounded_linked_list_engine_unit.sv =====
// Bounded singly linked list engine: a stream of list operations in,
// one result item out per operation.
//
// Request channel (req_*): req_tuser carries the operation (append,
// prepend, remove by value, remove last, remove first), req_tdata the
// signed value. Result channel (rsp_*): rsp_tuser carries the status
// (ok, list empty, store full, value not found), rsp_tdata the removed
// value and the list length after the operation.
//
// One item is processed at a time. Remove by value and remove last walk
// the next links one node per cycle through the node store read port.
// The sequencer holds its result until the output register can take it,
// and the result is then registered there. Reset empties the list and
// the free list at once; the node store is not cleared. A stalled result
// waits in the output register while the next item is already accepted
// and processed.
// Depends on blle_pkg, blle_store and blle_ctrl.
module bounded_linked_list_engine_unit #(
   parameter int DEPTH      = 256,
   parameter int DATA_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic [2:0]  req_tuser,   // [2:0] func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [31:0] removed_value, [40:32] count, [47:41] zero
   output logic [1:0]  rsp_tuser    // [1:0] status
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   blle_pkg::wr_ctl_type  wr_ctl;
   logic [AW-1:0]         wr_addr;
   logic [DATA_WIDTH-1:0] wr_value;
   logic [AW-1:0]         wr_link;
   logic [AW-1:0]         rd_addr;
   logic [DATA_WIDTH-1:0] rd_value;
   logic [AW-1:0]         rd_link;

   logic                  res_valid;
   logic                  res_ready;
   blle_pkg::status_type  res_status;
   logic [31:0]           res_value;
   logic [8:0]            res_count;

   logic                  rsp_valid_ff, rsp_valid_in;
   blle_pkg::status_type  rsp_status_ff, rsp_status_in;
   logic [31:0]           rsp_value_ff, rsp_value_in;
   logic [8:0]            rsp_count_ff, rsp_count_in;

   blle_store #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH),
      .AW         (AW)
   ) u_store (
      .clock    (clock),
      .wr_ctl   (wr_ctl),
      .wr_addr  (wr_addr),
      .wr_value (wr_value),
      .wr_link  (wr_link),
      .rd_addr  (rd_addr),
      .rd_value (rd_value),
      .rd_link  (rd_link)
   );

   blle_ctrl #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH),
      .AW         (AW),
      .CW         (CW)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_func   (req_tuser),
      .req_value  (req_tdata),
      .wr_ctl     (wr_ctl),
      .wr_addr    (wr_addr),
      .wr_value   (wr_value),
      .wr_link    (wr_link),
      .rd_addr    (rd_addr),
      .rd_value   (rd_value),
      .rd_link    (rd_link),
      .res_valid  (res_valid),
      .res_ready  (res_ready),
      .res_status (res_status),
      .res_value  (res_value),
      .res_count  (res_count)
   );

   // load the output register when it is empty or being drained
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_count_in  = rsp_count_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (res_valid && res_ready) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status;
         rsp_value_in  = res_value;
         rsp_count_in  = res_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_count_ff, rsp_value_ff};
   assign rsp_tuser  = rsp_status_ff;

endmodule

// ===== src/blle_store.sv =====
// Node store: value memory and next-link memory, one write and one read port.
// Read data is registered. Depends on blle_pkg.
module blle_store #(
   parameter int DEPTH      = 256,
   parameter int DATA_WIDTH = 32,
   parameter int AW         = 8
) (
   input  logic                   clock,
   input  blle_pkg::wr_ctl_type   wr_ctl,
   input  logic [AW-1:0]          wr_addr,
   input  logic [DATA_WIDTH-1:0]  wr_value,
   input  logic [AW-1:0]          wr_link,
   input  logic [AW-1:0]          rd_addr,
   output logic [DATA_WIDTH-1:0]  rd_value,
   output logic [AW-1:0]          rd_link
);

   logic [DATA_WIDTH-1:0] vals_mem [DEPTH];
   logic [AW-1:0]         links_mem [DEPTH];
   logic [DATA_WIDTH-1:0] rd_value_ff;
   logic [AW-1:0]         rd_link_ff;

   // write node value and link
   always_ff @(posedge clock) begin
      if (wr_ctl.val_we) begin
         vals_mem[wr_addr] <= wr_value;
      end
      if (wr_ctl.link_we) begin
         links_mem[wr_addr] <= wr_link;
      end
   end

   // registered read of both fields of one node
   always_ff @(posedge clock) begin
      rd_value_ff <= vals_mem[rd_addr];
      rd_link_ff  <= links_mem[rd_addr];
   end

   assign rd_value = rd_value_ff;
   assign rd_link  = rd_link_ff;

endmodule

// ===== src/blle_ctrl.sv =====
// Sequencer of the linked list engine: list pointers, free list, walks.
// Drives the node store ports of blle_store. Depends on blle_pkg.
module blle_ctrl #(
   parameter int DEPTH      = 256,
   parameter int DATA_WIDTH = 32,
   parameter int AW         = 8,
   parameter int CW         = 9
) (
   input  logic                   clock,
   input  logic                   reset,
   // request item
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [2:0]             req_func,
   input  logic signed [31:0]     req_value,
   // node store
   output blle_pkg::wr_ctl_type   wr_ctl,
   output logic [AW-1:0]          wr_addr,
   output logic [DATA_WIDTH-1:0]  wr_value,
   output logic [AW-1:0]          wr_link,
   output logic [AW-1:0]          rd_addr,
   input  logic [DATA_WIDTH-1:0]  rd_value,
   input  logic [AW-1:0]          rd_link,
   // result item
   output logic                   res_valid,
   input  logic                   res_ready,
   output blle_pkg::status_type   res_status,
   output logic [31:0]            res_value,
   output logic [8:0]             res_count
);

   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_ALLOC  = 9'b000000010,
      S_NODE   = 9'b000000100,
      S_TAIL   = 9'b000001000,
      S_TAKE   = 9'b000010000,
      S_WALK   = 9'b000100000,
      S_UNLINK = 9'b001000000,
      S_FREE   = 9'b010000000,
      S_RESP   = 9'b100000000
   } state_type;

   state_type             state_ff, state_in;
   logic [2:0]            func_ff, func_in;
   logic [DATA_WIDTH-1:0] val_ff, val_in;
   logic [AW-1:0]         cur_ff, cur_in;
   logic [AW-1:0]         prev_ff, prev_in;
   logic [AW-1:0]         rel_ff, rel_in;
   logic [AW-1:0]         ulink_ff, ulink_in;
   logic [CW-1:0]         pos_ff, pos_in;
   logic [AW-1:0]         head_ff, head_in;
   logic [AW-1:0]         tail_ff, tail_in;
   logic [AW-1:0]         free_head_ff, free_head_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [CW-1:0]         free_count_ff, free_count_in;
   logic [CW-1:0]         fresh_ff, fresh_in;
   blle_pkg::status_type  status_ff, status_in;
   logic [31:0]           taken_ff, taken_in;

   logic signed [DATA_WIDTH-1:0] rd_value_s;
   logic [CW-1:0]                cnt_m1;
   logic [CW-1:0]                cnt_m2;
   logic                         is_full;

   assign rd_value_s = rd_value;
   assign cnt_m1     = count_ff - CW'(1);
   assign cnt_m2     = count_ff - CW'(2);
   assign is_full    = (count_ff == CW'(DEPTH));

   // next state and datapath
   always_comb begin
      state_in      = state_ff;
      func_in       = func_ff;
      val_in        = val_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      rel_in        = rel_ff;
      ulink_in      = ulink_ff;
      pos_in        = pos_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      free_head_in  = free_head_ff;
      count_in      = count_ff;
      free_count_in = free_count_ff;
      fresh_in      = fresh_ff;
      status_in     = status_ff;
      taken_in      = taken_ff;
      rd_addr       = cur_ff;
      wr_ctl        = '0;
      wr_addr       = cur_ff;
      wr_value      = val_ff;
      wr_link       = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               func_in   = req_func;
               val_in    = DATA_WIDTH'(req_value);
               status_in = blle_pkg::ST_OK;
               taken_in  = '0;
               pos_in    = '0;
               case (req_func)
                  blle_pkg::FUNC_APPEND,
                  blle_pkg::FUNC_PREPEND: begin
                     if (is_full) begin
                        status_in = blle_pkg::ST_FULL;
                        state_in  = S_RESP;
                     end else if (free_count_ff != '0) begin
                        // reuse a released node: fetch its link to pop the free list
                        rd_addr  = free_head_ff;
                        cur_in   = free_head_ff;
                        state_in = S_ALLOC;
                     end else begin
                        cur_in   = fresh_ff[AW-1:0];
                        fresh_in = fresh_ff + CW'(1);
                        state_in = S_NODE;
                     end
                  end
                  blle_pkg::FUNC_REMOVE_VAL,
                  blle_pkg::FUNC_REMOVE_FIRST: begin
                     if (count_ff == '0) begin
                        status_in = blle_pkg::ST_EMPTY;
                        state_in  = S_RESP;
                     end else begin
                        rd_addr  = head_ff;
                        cur_in   = head_ff;
                        state_in = S_WALK;
                     end
                  end
                  blle_pkg::FUNC_REMOVE_LAST: begin
                     if (count_ff == '0) begin
                        status_in = blle_pkg::ST_EMPTY;
                        state_in  = S_RESP;
                     end else begin
                        rd_addr  = tail_ff;
                        rel_in   = tail_ff;
                        state_in = S_TAKE;
                     end
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end
         end

         S_ALLOC: begin
            // pop the free list
            free_head_in  = rd_link;
            free_count_in = free_count_ff - CW'(1);
            state_in      = S_NODE;
         end

         S_NODE: begin
            // write the new node, then hook it into the list
            wr_ctl.val_we  = 1'b1;
            wr_ctl.link_we = 1'b1;
            wr_addr        = cur_ff;
            wr_value       = val_ff;
            count_in       = count_ff + CW'(1);
            state_in       = S_RESP;
            if (count_ff == '0) begin
               head_in = cur_ff;
               tail_in = cur_ff;
            end else if (func_ff == blle_pkg::FUNC_APPEND) begin
               state_in = S_TAIL;
            end else begin
               wr_link = head_ff;
               head_in = cur_ff;
            end
         end

         S_TAIL: begin
            // link old tail to the new node
            wr_ctl.link_we = 1'b1;
            wr_addr        = tail_ff;
            wr_link        = cur_ff;
            tail_in        = cur_ff;
            state_in       = S_RESP;
         end

         S_TAKE: begin
            // value of the last node is in hand; find its predecessor if any
            taken_in = 32'(rd_value_s);
            if (count_ff > CW'(1)) begin
               rd_addr  = head_ff;
               cur_in   = head_ff;
               state_in = S_WALK;
            end else begin
               state_in = S_FREE;
            end
         end

         S_WALK: begin
            // node cur_ff at position pos_ff is on the read port
            case (func_ff)
               blle_pkg::FUNC_REMOVE_FIRST: begin
                  taken_in = 32'(rd_value_s);
                  head_in  = rd_link;
                  rel_in   = cur_ff;
                  state_in = S_FREE;
               end
               blle_pkg::FUNC_REMOVE_VAL: begin
                  if (rd_value == val_ff) begin
                     rel_in = cur_ff;
                     if (pos_ff == '0) begin
                        head_in  = rd_link;
                        state_in = S_FREE;
                     end else begin
                        ulink_in = rd_link;
                        if (cur_ff == tail_ff) begin
                           tail_in = prev_ff;
                        end
                        state_in = S_UNLINK;
                     end
                  end else if (pos_ff == cnt_m1) begin
                     status_in = blle_pkg::ST_MISSING;
                     state_in  = S_RESP;
                  end else begin
                     prev_in = cur_ff;
                     cur_in  = rd_link;
                     rd_addr = rd_link;
                     pos_in  = pos_ff + CW'(1);
                  end
               end
               blle_pkg::FUNC_REMOVE_LAST: begin
                  if (pos_ff == cnt_m2) begin
                     prev_in  = cur_ff;
                     tail_in  = cur_ff;
                     ulink_in = '0;
                     state_in = S_UNLINK;
                  end else begin
                     cur_in  = rd_link;
                     rd_addr = rd_link;
                     pos_in  = pos_ff + CW'(1);
                  end
               end
               default: begin
                  state_in = S_RESP;
               end
            endcase
         end

         S_UNLINK: begin
            // bypass the removed node
            wr_ctl.link_we = 1'b1;
            wr_addr        = prev_ff;
            wr_link        = ulink_ff;
            state_in       = S_FREE;
         end

         S_FREE: begin
            // push the removed node on the free list
            wr_ctl.link_we = 1'b1;
            wr_addr        = rel_ff;
            wr_link        = free_head_ff;
            free_head_in   = rel_ff;
            free_count_in  = free_count_ff + CW'(1);
            count_in       = cnt_m1;
            if (count_ff == CW'(1)) begin
               head_in = '0;
               tail_in = '0;
            end
            state_in = S_RESP;
         end

         S_RESP: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         head_ff       <= '0;
         tail_ff       <= '0;
         free_head_ff  <= '0;
         count_ff      <= '0;
         free_count_ff <= '0;
         fresh_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         free_head_ff  <= free_head_in;
         count_ff      <= count_in;
         free_count_ff <= free_count_in;
         fresh_ff      <= fresh_in;
      end
   end

   // item payload and walk registers
   always_ff @(posedge clock) begin
      func_ff   <= func_in;
      val_ff    <= val_in;
      cur_ff    <= cur_in;
      prev_ff   <= prev_in;
      rel_ff    <= rel_in;
      ulink_ff  <= ulink_in;
      pos_ff    <= pos_in;
      status_ff <= status_in;
      taken_ff  <= taken_in;
   end

   assign req_ready  = (state_ff == S_IDLE);
   assign res_valid  = (state_ff == S_RESP);
   assign res_status = status_ff;
   assign res_value  = taken_ff;
   assign res_count  = 9'(count_ff);

endmodule
